### hdl/fcte_pkg.sv
// ----------------------------------------------------------------------------
// fcte_pkg
// Shared types and constants of the cluster link table engine: request and
// status codes, entry formats, register map, controller command and status.
// ----------------------------------------------------------------------------
package fcte_pkg;

    localparam int CLUSTER_W  = 28;
    localparam int LIMIT_W    = 17;
    localparam int MODE_W     = 2;
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // request codes
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FREE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAN = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STEP_LIMIT = 2'd2;

    // entry formats
    localparam logic [MODE_W-1:0] MODE_FAT12 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FAT16 = 2'd1;

    localparam logic [CLUSTER_W-1:0] MASK12   = 28'h0000FFF;
    localparam logic [CLUSTER_W-1:0] MASK16   = 28'h000FFFF;
    localparam logic [CLUSTER_W-1:0] MASK28   = 28'hFFFFFFF;
    localparam logic [CLUSTER_W-1:0] EOC12    = 28'h0000FF8;
    localparam logic [CLUSTER_W-1:0] EOC16    = 28'h000FFF8;
    localparam logic [CLUSTER_W-1:0] EOC_READ = 28'hFFFFFF8;

    // register index, taken from paddr[2]
    localparam logic REG_FAT_MODE      = 1'b0;
    localparam logic REG_CLUSTER_LIMIT = 1'b1;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic exec;
        logic al_rd;
        logic al_ck;
        logic fr_rd;
        logic fr_wr;
        logic out_load;
    } fcte_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             clr_done;
        logic             cur_valid;
        logic             step_hit;
        logic             scan_end;
        logic             entry_free;
        logic             link_end;
    } fcte_sts_t;

    function automatic logic [CLUSTER_W-1:0] mode_mask(input logic [MODE_W-1:0] mode);
        logic [CLUSTER_W-1:0] m;
        case (mode)
            MODE_FAT12: m = MASK12;
            MODE_FAT16: m = MASK16;
            default:    m = MASK28;
        endcase
        return m;
    endfunction

    function automatic logic [CLUSTER_W-1:0] mode_eoc(input logic [MODE_W-1:0] mode);
        logic [CLUSTER_W-1:0] e;
        case (mode)
            MODE_FAT12: e = EOC12;
            MODE_FAT16: e = EOC16;
            default:    e = EOC_READ;
        endcase
        return e;
    endfunction

endpackage

### hdl/fcte_ctrl.sv
// ----------------------------------------------------------------------------
// fcte_ctrl
// Request sequencer: clearing pass, dispatch, allocate scan, chain walk and
// result delivery into the output register.
// ----------------------------------------------------------------------------
module fcte_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  fcte_pkg::fcte_sts_t sts,
    output fcte_pkg::fcte_cmd_t cmd
);
    import fcte_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_AL_RD = 3'd3;
    localparam logic [2:0] S_AL_CK = 3'd4;
    localparam logic [2:0] S_FR_RD = 3'd5;
    localparam logic [2:0] S_FR_WR = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                case (sts.req)
                    REQ_ALLOC: state_next = S_AL_RD;
                    REQ_FREE:  state_next = S_FR_RD;
                    default:   state_next = S_DONE;
                endcase
            end
            S_AL_RD: begin
                cmd.al_rd  = 1'b1;
                state_next = sts.scan_end ? S_DONE : S_AL_CK;
            end
            S_AL_CK: begin
                cmd.al_ck  = 1'b1;
                state_next = sts.entry_free ? S_DONE : S_AL_RD;
            end
            S_FR_RD: begin
                cmd.fr_rd  = 1'b1;
                state_next = (!sts.cur_valid || sts.step_hit) ? S_DONE : S_FR_WR;
            end
            S_FR_WR: begin
                cmd.fr_wr  = 1'b1;
                state_next = sts.link_end ? S_DONE : S_FR_RD;
            end
            S_DONE: begin
                // hold the result until the output register has room
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### hdl/fcte_dp.sv
// ----------------------------------------------------------------------------
// fcte_dp
// Datapath: link table memory, request registers, scan and step counters,
// dirty flag, result and output registers.
// ----------------------------------------------------------------------------
module fcte_dp #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  fcte_pkg::fcte_cmd_t                  cmd,
    output fcte_pkg::fcte_sts_t                  sts,
    input  logic [fcte_pkg::MODE_W-1:0]          fat_mode,
    input  logic [fcte_pkg::LIMIT_W-1:0]         cluster_limit,
    input  logic [fcte_pkg::REQ_W-1:0]           s_req_type,
    input  logic [fcte_pkg::CLUSTER_W-1:0]       s_cluster,
    input  logic [fcte_pkg::CLUSTER_W-1:0]       s_value,
    output logic [fcte_pkg::STATUS_W-1:0]        m_status,
    output logic [fcte_pkg::CLUSTER_W-1:0]       m_entry_value,
    output logic                                 m_dirty
);
    import fcte_pkg::*;

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int LW  = CLUSTER_W + 1;
    localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    logic [CLUSTER_W-1:0] link_mem [TABLE_DEPTH];
    logic [CLUSTER_W-1:0] rdata_reg;

    logic [REQ_W-1:0]     req_reg;
    logic [CLUSTER_W-1:0] cur_reg;
    logic [CLUSTER_W-1:0] value_reg;
    logic [AW:0]          scan_reg;
    logic [LIMIT_W-1:0]   steps_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [CLUSTER_W-1:0] result_reg;
    logic                 dirty_reg;
    logic [AW-1:0]        clr_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [CLUSTER_W-1:0] m_entry_value_reg;
    logic                 m_dirty_reg;

    logic [CLUSTER_W-1:0] mask;
    logic [CLUSTER_W-1:0] eoc;
    logic [CLUSTER_W-1:0] link;
    logic [LW-1:0]        lim_ext;
    logic [LW-1:0]        eff_lim;
    logic [LW-1:0]        cur_ext;
    logic                 cur_valid;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [CLUSTER_W-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;

    assign mask    = mode_mask(fat_mode);
    assign eoc     = mode_eoc(fat_mode);
    assign link    = rdata_reg & mask;
    assign lim_ext = LW'(cluster_limit);
    assign eff_lim = (lim_ext > DEPTH_L) ? DEPTH_L : lim_ext;
    assign cur_ext = LW'(cur_reg);
    assign cur_valid = (cur_ext >= LW'(2)) && (cur_ext < eff_lim);

    assign sts.req        = req_reg;
    assign sts.clr_done   = (clr_reg == LAST_IDX);
    assign sts.cur_valid  = cur_valid;
    assign sts.step_hit   = (steps_reg >= cluster_limit);
    assign sts.scan_end   = (LW'(scan_reg) >= eff_lim);
    assign sts.entry_free = (link == '0);
    assign sts.link_end   = (link >= eoc);

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg[AW-1:0];
        mem_wdata = '0;
        mem_raddr = cur_reg[AW-1:0];
        if (cmd.accept) begin
            mem_raddr = s_cluster[AW-1:0];
        end else if (cmd.al_rd) begin
            mem_raddr = scan_reg[AW-1:0];
        end
        if (cmd.clear_step) begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
        end else if (cmd.exec && req_reg == REQ_WRITE && cur_valid) begin
            mem_we    = 1'b1;
            mem_wdata = value_reg & mask;
        end else if (cmd.al_ck && sts.entry_free) begin
            mem_we    = 1'b1;
            mem_waddr = scan_reg[AW-1:0];
            mem_wdata = eoc;
        end else if (cmd.fr_wr) begin
            mem_we    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= link_mem[mem_raddr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_reg <= 1'b0;
            clr_reg   <= '0;
        end else begin
            if (cmd.clear_step) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (mem_we && !cmd.clear_step) begin
                dirty_reg <= 1'b1;
            end else if (cmd.exec && req_reg == REQ_CLEAN) begin
                dirty_reg <= 1'b0;
            end
        end
    end

    // request payload and working registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg    <= s_req_type;
            cur_reg    <= s_cluster;
            value_reg  <= s_value;
            scan_reg   <= (AW+1)'(2);
            steps_reg  <= '0;
            status_reg <= ST_OK;
            result_reg <= '0;
        end
        if (cmd.exec && req_reg == REQ_READ) begin
            result_reg <= cur_valid ? link : EOC_READ;
        end
        if (cmd.al_rd && sts.scan_end) begin
            status_reg <= ST_NO_FREE;
        end
        if (cmd.al_ck) begin
            if (sts.entry_free) begin
                result_reg <= CLUSTER_W'(scan_reg);
            end else begin
                scan_reg <= scan_reg + (AW+1)'(1);
            end
        end
        if (cmd.fr_rd && cur_valid && sts.step_hit) begin
            status_reg <= ST_STEP_LIMIT;
        end
        if (cmd.fr_wr) begin
            steps_reg <= steps_reg + LIMIT_W'(1);
            if (!sts.link_end) begin
                cur_reg <= link;
            end
        end
        if (cmd.out_load) begin
            m_status_reg      <= status_reg;
            m_entry_value_reg <= result_reg;
            m_dirty_reg       <= dirty_reg;
        end
    end

    assign m_status      = m_status_reg;
    assign m_entry_value = m_entry_value_reg;
    assign m_dirty       = m_dirty_reg;

endmodule

### hdl/fat_cluster_table_engine.sv
// ----------------------------------------------------------------------------
// fat_cluster_table_engine
// File allocation table engine: read, write, allocate, free chain and
// mark-clean requests against a link table of TABLE_DEPTH entries.
//
//   channel   dir  handshake        payload
//   apb       in   psel/penable     paddr, pwdata, prdata (fat_mode, cluster_limit)
//   s_        in   s_valid/s_ready  s_req_type, s_cluster, s_value
//   m_        out  m_valid/m_ready  m_status, m_entry_value, m_dirty
//
// Read, write, mark-clean and unknown requests step through accept, execute
// and load; allocate adds a read and a check per entry scanned and free chain
// a read and a write per link cleared, plus a final read when the scan runs out
// or the walk stops on an invalid cluster or the step limit.
// After reset a clearing pass zeroes every entry of the memory with
// s_ready low. A result waiting on m_ready does not block the next accept;
// a second result waits in the engine until the output register empties.
// ----------------------------------------------------------------------------
module fat_cluster_table_engine #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fcte_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [fcte_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [fcte_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [fcte_pkg::REQ_W-1:0]           s_req_type,
    input  logic [fcte_pkg::CLUSTER_W-1:0]       s_cluster,
    input  logic [fcte_pkg::CLUSTER_W-1:0]       s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [fcte_pkg::STATUS_W-1:0]        m_status,
    output logic [fcte_pkg::CLUSTER_W-1:0]       m_entry_value,
    output logic                                 m_dirty
);
    import fcte_pkg::*;

    logic [MODE_W-1:0]  fat_mode_reg;
    logic [LIMIT_W-1:0] cluster_limit_reg;
    logic               reg_idx;
    logic               cfg_wr;
    fcte_cmd_t          cmd;
    fcte_sts_t          sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fat_mode_reg      <= MODE_FAT12;
            cluster_limit_reg <= LIMIT_W'(2);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_FAT_MODE:      fat_mode_reg      <= pwdata[MODE_W-1:0];
                REG_CLUSTER_LIMIT: cluster_limit_reg <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FAT_MODE:      prdata = APB_DATA_W'(fat_mode_reg);
            REG_CLUSTER_LIMIT: prdata = APB_DATA_W'(cluster_limit_reg);
            default:           prdata = '0;
        endcase
    end

    fcte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fcte_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .fat_mode      (fat_mode_reg),
        .cluster_limit (cluster_limit_reg),
        .s_req_type    (s_req_type),
        .s_cluster     (s_cluster),
        .s_value       (s_value),
        .m_status      (m_status),
        .m_entry_value (m_entry_value),
        .m_dirty       (m_dirty)
    );

    // the clearing pass starts right after reset, so no beat is taken then
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken during clearing pass");

    a_error_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_entry_value == '0))
        else $error("failed request carries a nonzero entry value");

    a_load_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result loaded over an untaken beat");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second beat taken while a request is at work");

endmodule
